/* hdl/prl_pkg.sv */
package prl_pkg;

  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_REM_HEAD  = 3'd1,
    OP_ADVANCE   = 3'd2,
    OP_REM_PID   = 3'd3,
    OP_REM_CUR   = 3'd4,
    OP_LOOKUP    = 3'd5
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the request
    logic exec;     // apply the operation to the slot chain
  } prl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
  } prl_sts_t;

endpackage

/* hdl/priority_ready_list_with_cursor.sv */
// The request is captured at the accepting edge, applied in the execute state, and the result is registered.
// A new start is not taken while busy: the block takes it again once the execute state is over.
// busy is high for the single execute cycle after each accepted start.
// The receiver cannot stall: each result shows on out_valid for one cycle.
// Synchronous reset empties the list, clears the cursor and the count.
module priority_ready_list_with_cursor #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_proc_id,
  input  logic [7:0]  in_prio,
  input  logic [15:0] in_ticket_count,
  output logic        out_valid,
  output logic        out_ok,
  output logic [15:0] out_entry_pid,
  output logic [7:0]  out_entry_prio,
  output logic [15:0] out_entry_tickets,
  output logic [15:0] out_head_pid,
  output logic        out_is_empty,
  output logic [$clog2(DEPTH+1)-1:0] out_occupancy
);

  prl_pkg::prl_cmd_t cmd;
  prl_pkg::prl_sts_t sts;

  prl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd)
  );

  prl_dp #(.DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_proc_id(in_proc_id),
    .in_prio(in_prio), .in_ticket_count(in_ticket_count),
    .out_ok(out_ok), .out_entry_pid(out_entry_pid),
    .out_entry_prio(out_entry_prio), .out_entry_tickets(out_entry_tickets),
    .out_head_pid(out_head_pid), .out_is_empty(out_is_empty),
    .out_occupancy(out_occupancy)
  );

  assign out_valid = sts.done;

endmodule

/* hdl/prl_ctrl.sv */
module prl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output prl_pkg::prl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r == ST_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* hdl/prl_dp.sv */
module prl_dp #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  prl_pkg::prl_cmd_t cmd,
  output prl_pkg::prl_sts_t sts,
  input  logic [2:0]        in_operation,
  input  logic [15:0]       in_proc_id,
  input  logic [7:0]        in_prio,
  input  logic [15:0]       in_ticket_count,
  output logic              out_ok,
  output logic [15:0]       out_entry_pid,
  output logic [7:0]        out_entry_prio,
  output logic [15:0]       out_entry_tickets,
  output logic [15:0]       out_head_pid,
  output logic              out_is_empty,
  output logic [$clog2(DEPTH+1)-1:0] out_occupancy
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [15:0] pid_r [DEPTH];
  logic [7:0]  pri_r [DEPTH];
  logic [15:0] tk_r  [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [2:0]  op_r;
  logic [15:0] rpid_r, rtk_r;
  logic [7:0]  rpri_r;

  // per-cell compare flags
  logic [DEPTH-1:0] gt, hit, first_hit;
  logic [IW-1:0] ins_k, hit_k, k;
  logic full, empty, found, do_ins, do_rem, ok;
  logic [IW-1:0] last;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i]  = vld_r[i] && (pri_r[i] > rpri_r);
      hit[i] = vld_r[i] && (pid_r[i] == rpid_r);
    end
  end

  // first set flag: each cell sees whether any earlier cell matched
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      first_hit[i] = hit[i] && !seen;
      seen = seen | hit[i];
    end
  end

  always_comb begin
    ins_k = cnt_r[IW-1:0];
    hit_k = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (gt[i]) ins_k = IW'(i);
      if (first_hit[i]) hit_k = IW'(i);
    end
  end

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign found = |hit;
  assign last  = IW'(cnt_r - CW'(1));

  always_comb begin
    do_ins = 1'b0;
    do_rem = 1'b0;
    ok     = 1'b0;
    k      = '0;
    cur_nxt = cur_r;
    cnt_nxt = cnt_r;
    unique case (op_r)
      3'(prl_pkg::OP_INSERT): begin
        if (!full) begin
          ok = 1'b1; do_ins = 1'b1; k = ins_k;
          cnt_nxt = cnt_r + CW'(1);
          if (empty) cur_nxt = '0;
          else if (ins_k <= cur_r) cur_nxt = cur_r + IW'(1);
        end
      end
      3'(prl_pkg::OP_REM_HEAD), 3'(prl_pkg::OP_REM_CUR), 3'(prl_pkg::OP_REM_PID): begin
        if (op_r == 3'(prl_pkg::OP_REM_PID)) begin
          ok = found; k = hit_k;
        end else begin
          ok = !empty;
          k = (op_r == 3'(prl_pkg::OP_REM_HEAD)) ? '0 : cur_r;
        end
        if (ok) begin
          do_rem = 1'b1;
          cnt_nxt = cnt_r - CW'(1);
          if (k == '0) begin
            if (cur_r != '0) cur_nxt = cur_r - IW'(1);
          end else if (op_r == 3'(prl_pkg::OP_REM_CUR)) begin
            cur_nxt = k - IW'(1);
          end else if (cur_r == k) begin
            if (k == last) cur_nxt = '0;
          end else if (cur_r > k) begin
            cur_nxt = cur_r - IW'(1);
          end
          // wrap when the cursor falls off the shortened list
          if (cnt_nxt == '0 || CW'(cur_nxt) >= cnt_nxt) cur_nxt = '0;
        end
      end
      3'(prl_pkg::OP_ADVANCE): begin
        if (!empty) begin
          ok = 1'b1;
          cur_nxt = (CW'(cur_r) + CW'(1) < cnt_r) ? cur_r + IW'(1) : '0;
          k = cur_nxt;
        end
      end
      3'(prl_pkg::OP_LOOKUP): begin
        ok = found; k = hit_k;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      rpid_r <= in_proc_id;
      rpri_r <= in_prio;
      rtk_r  <= in_ticket_count;
    end
  end

  // shift chain: each cell takes from its neighbour, itself or the request
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (do_ins && IW'(i) == k) begin
          pid_r[i] <= rpid_r; pri_r[i] <= rpri_r; tk_r[i] <= rtk_r;
        end else if (do_ins && IW'(i) > k && i > 0) begin
          pid_r[i] <= pid_r[i-1]; pri_r[i] <= pri_r[i-1]; tk_r[i] <= tk_r[i-1];
        end else if (do_rem && IW'(i) >= k && i < DEPTH - 1) begin
          pid_r[i] <= pid_r[i+1]; pri_r[i] <= pri_r[i+1]; tk_r[i] <= tk_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cur_r <= '0;
      cnt_r <= '0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= cmd.exec;
      if (cmd.exec) begin
        cur_r <= cur_nxt;
        cnt_r <= cnt_nxt;
        for (int i = 0; i < DEPTH; i++) vld_r[i] <= (CW'(i) < cnt_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_ok <= ok;
      out_occupancy <= cnt_nxt;
      out_is_empty  <= (cnt_nxt == '0);
      if (!ok) begin
        out_entry_pid <= '0; out_entry_prio <= '0; out_entry_tickets <= '0;
      end else if (do_ins) begin
        out_entry_pid <= rpid_r; out_entry_prio <= rpri_r; out_entry_tickets <= rtk_r;
      end else begin
        out_entry_pid <= pid_r[k]; out_entry_prio <= pri_r[k]; out_entry_tickets <= tk_r[k];
      end
      // head after the operation
      if (cnt_nxt == '0)                     out_head_pid <= '0;
      else if (do_ins && k == '0)            out_head_pid <= rpid_r;
      else if (do_rem && k == '0)            out_head_pid <= pid_r[1];
      else                                   out_head_pid <= pid_r[0];
    end
  end

endmodule

/* hdl/prl_checker.sv */
module prl_checker #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_ok,
  input logic [15:0] out_entry_pid,
  input logic        out_is_empty,
  input logic [$clog2(DEPTH+1)-1:0] out_occupancy
);

  // an accepted item is captured, then executed, and its result shows on out_valid
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid) else $error("missing result");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_entry_pid == 16'd0)) else $error("entry on failure");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= ($clog2(DEPTH+1))'(DEPTH))) else $error("over capacity");

endmodule

bind priority_ready_list_with_cursor prl_checker #(.DEPTH(DEPTH)) u_prl_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_ok(out_ok), .out_entry_pid(out_entry_pid),
  .out_is_empty(out_is_empty), .out_occupancy(out_occupancy)
);

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH = 16;
  localparam logic [2:0] OP_BAD_A = 3'd6;
  localparam logic [2:0] OP_BAD_B = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_operation;
  logic [15:0] in_proc_id;
  logic [7:0]  in_prio;
  logic [15:0] in_ticket_count;
  logic        out_valid;
  logic        out_ok;
  logic [15:0] out_entry_pid;
  logic [7:0]  out_entry_prio;
  logic [15:0] out_entry_tickets;
  logic [15:0] out_head_pid;
  logic        out_is_empty;
  logic [4:0]  out_occupancy;

  typedef struct packed {
    logic        ok;
    logic [15:0] pid;
    logic [7:0]  prio;
    logic [15:0] tickets;
    logic [15:0] head;
    logic        empty;
    logic [4:0]  occ;
  } sched_res_t;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] pid;
    logic [7:0]  prio;
    logic [15:0] tk;
    logic        typed;
    sched_res_t  res;
  } row_t;

  priority_ready_list_with_cursor #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_proc_id(in_proc_id), .in_prio(in_prio),
    .in_ticket_count(in_ticket_count), .out_valid(out_valid), .out_ok(out_ok),
    .out_entry_pid(out_entry_pid), .out_entry_prio(out_entry_prio),
    .out_entry_tickets(out_entry_tickets), .out_head_pid(out_head_pid),
    .out_is_empty(out_is_empty), .out_occupancy(out_occupancy)
  );

  // predictor state
  logic [15:0] q_pid [DEPTH];
  logic [7:0]  q_prio [DEPTH];
  logic [15:0] q_tk [DEPTH];
  int          q_cur;
  int          q_cnt;

  sched_res_t  pending_res[$];
  int          errors;
  int          send_idle;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb failed");
    $finish;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic unlink(int k, bit at_cur);
    int last;
    last = q_cnt - 1;
    if (k == 0) begin
      if (q_cur > 0) q_cur--;
    end else if (at_cur) begin
      q_cur = k - 1;
    end else if (q_cur == k) begin
      if (k == last) q_cur = 0;
    end else if (q_cur > k) begin
      q_cur--;
    end
    for (int i = k; i + 1 < q_cnt; i++) begin
      q_pid[i] = q_pid[i+1]; q_prio[i] = q_prio[i+1]; q_tk[i] = q_tk[i+1];
    end
    q_cnt--;
    if (q_cnt == 0 || q_cur >= q_cnt) q_cur = 0;
  endtask

  function automatic int find_pid(logic [15:0] pid);
    for (int i = 0; i < q_cnt; i++) if (q_pid[i] == pid) return i;
    return q_cnt;
  endfunction

  task automatic schedule_step(input logic [2:0] op, input logic [15:0] pid,
                               input logic [7:0] pr, input logic [15:0] tk,
                               output sched_res_t r);
    int k;
    r = '0;
    case (op)
      prl_pkg::OP_INSERT: if (q_cnt < DEPTH) begin
        k = 0;
        while (k < q_cnt && q_prio[k] <= pr) k++;
        for (int i = q_cnt; i > k; i--) begin
          q_pid[i] = q_pid[i-1]; q_prio[i] = q_prio[i-1]; q_tk[i] = q_tk[i-1];
        end
        q_pid[k] = pid; q_prio[k] = pr; q_tk[k] = tk;
        if (q_cnt == 0) q_cur = 0;
        else if (k <= q_cur) q_cur++;
        q_cnt++;
        r.ok = 1; r.pid = pid; r.prio = pr; r.tickets = tk;
      end
      prl_pkg::OP_REM_HEAD, prl_pkg::OP_REM_CUR: if (q_cnt > 0) begin
        k = (op == prl_pkg::OP_REM_HEAD) ? 0 : q_cur;
        r.ok = 1; r.pid = q_pid[k]; r.prio = q_prio[k]; r.tickets = q_tk[k];
        unlink(k, op == prl_pkg::OP_REM_CUR);
      end
      prl_pkg::OP_ADVANCE: if (q_cnt > 0) begin
        q_cur = (q_cur + 1 < q_cnt) ? q_cur + 1 : 0;
        r.ok = 1; r.pid = q_pid[q_cur]; r.prio = q_prio[q_cur];
        r.tickets = q_tk[q_cur];
      end
      prl_pkg::OP_REM_PID, prl_pkg::OP_LOOKUP: begin
        k = find_pid(pid);
        if (k < q_cnt) begin
          r.ok = 1; r.pid = q_pid[k]; r.prio = q_prio[k]; r.tickets = q_tk[k];
          if (op == prl_pkg::OP_REM_PID) unlink(k, 0);
        end
      end
      default: ;
    endcase
    r.head = q_cnt > 0 ? q_pid[0] : 16'd0;
    r.empty = q_cnt == 0;
    r.occ = q_cnt[4:0];
  endtask

  // result checker
  always @(posedge clk) begin
    sched_res_t w;
    if (rst_n && out_valid) begin
      if (pending_res.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        w = pending_res.pop_front();
        if (out_ok !== w.ok) report("ok", out_ok, w.ok);
        if (out_entry_pid !== w.pid) report("entry_pid", out_entry_pid, w.pid);
        if (out_entry_prio !== w.prio) report("entry_prio", out_entry_prio, w.prio);
        if (out_entry_tickets !== w.tickets)
          report("entry_tickets", out_entry_tickets, w.tickets);
        if (out_head_pid !== w.head) report("head_pid", out_head_pid, w.head);
        if (out_is_empty !== w.empty) report("is_empty", out_is_empty, w.empty);
        if (out_occupancy !== w.occ) report("occupancy", out_occupancy, w.occ);
      end
    end
  end

  // start stays high after an accepted item; the next call (its idle loop or its item) or the final clear drives it
  task automatic send_item(logic [2:0] op, logic [15:0] pid, logic [7:0] pr,
                           logic [15:0] tk, bit typed, sched_res_t tr);
    sched_res_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; in_operation <= op; in_proc_id <= pid;
    in_prio <= pr; in_ticket_count <= tk;
    @(posedge clk);
    while (busy) @(posedge clk);
    schedule_step(op, pid, pr, tk, r);
    if (typed && r !== tr) report("typed row", tr, r);
    pending_res.push_back(r);
  endtask

  function automatic sched_res_t mk(logic ok, logic [15:0] p, logic [7:0] pr,
      logic [15:0] t, logic [15:0] h, logic e, logic [4:0] o);
    mk = '{ok, p, pr, t, h, e, o};
  endfunction

  row_t dir_rows[$];

  initial begin
    sched_res_t none;
    logic [2:0] op;
    logic [15:0] pid;
    int ph, n, wait_c;
    none = '0;
    errors = 0;
    send_idle = 0;
    q_cur = 0; q_cnt = 0;
    rst_n <= 0; start <= 0; in_operation <= '0; in_proc_id <= '0;
    in_prio <= '0; in_ticket_count <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty-list rejects, then extremes, duplicates, full list
    dir_rows.push_back('{prl_pkg::OP_REM_HEAD, 16'd0, 8'd0, 16'd0, 1, mk(0,0,0,0,0,1,0)});
    dir_rows.push_back('{prl_pkg::OP_ADVANCE, 16'd0, 8'd0, 16'd0, 1, mk(0,0,0,0,0,1,0)});
    dir_rows.push_back('{prl_pkg::OP_REM_CUR, 16'd0, 8'd0, 16'd0, 1, mk(0,0,0,0,0,1,0)});
    dir_rows.push_back('{prl_pkg::OP_LOOKUP, 16'hffff, 8'd0, 16'd0, 1, mk(0,0,0,0,0,1,0)});
    dir_rows.push_back('{OP_BAD_A, 16'hffff, 8'hff, 16'hffff, 1, mk(0,0,0,0,0,1,0)});
    dir_rows.push_back('{OP_BAD_B, 16'h0, 8'h0, 16'h0, 1, mk(0,0,0,0,0,1,0)});
    dir_rows.push_back('{prl_pkg::OP_INSERT, 16'hffff, 8'hff, 16'hffff, 1,
                         mk(1,16'hffff,8'hff,16'hffff,16'hffff,0,1)});
    dir_rows.push_back('{prl_pkg::OP_INSERT, 16'h0, 8'h0, 16'h0, 1, mk(1,0,0,0,0,0,2)});
    dir_rows.push_back('{prl_pkg::OP_INSERT, 16'h5, 8'h80, 16'h1234, 0, none});
    dir_rows.push_back('{prl_pkg::OP_INSERT, 16'h5, 8'h80, 16'h4321, 0, none});
    dir_rows.push_back('{prl_pkg::OP_LOOKUP, 16'h5, 8'h0, 16'h0, 0, none});
    dir_rows.push_back('{prl_pkg::OP_ADVANCE, 16'h0, 8'h0, 16'h0, 0, none});
    dir_rows.push_back('{prl_pkg::OP_ADVANCE, 16'h0, 8'h0, 16'h0, 0, none});
    dir_rows.push_back('{prl_pkg::OP_REM_CUR, 16'h0, 8'h0, 16'h0, 0, none});
    dir_rows.push_back('{prl_pkg::OP_REM_PID, 16'h5, 8'h0, 16'h0, 0, none});
    dir_rows.push_back('{prl_pkg::OP_REM_PID, 16'h77, 8'h0, 16'h0, 0, none});
    dir_rows.push_back('{prl_pkg::OP_REM_HEAD, 16'h0, 8'h0, 16'h0, 0, none});
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].pid, dir_rows[i].prio, dir_rows[i].tk,
                dir_rows[i].typed, dir_rows[i].res);
    // fill to the brim, then two inserts too many
    for (int i = 0; i < DEPTH + 1; i++)
      send_item(prl_pkg::OP_INSERT, 16'($urandom), 8'($urandom_range(3)),
                16'($urandom), 0, none);

    for (int i = 0; i < 2000; i++) begin
      ph = i * 3 / 2000;
      send_idle = (ph == 0) ? 10 : (ph == 1) ? 66 : 0;
      n = $urandom_range(99);
      // bias towards inserts when near empty, removals when near full
      if (n < 5) op = 3'($urandom_range(7));
      else if (n < 45 - (q_cnt > 12 ? 20 : 0) + (q_cnt < 3 ? 20 : 0)) op = prl_pkg::OP_INSERT;
      else op = 3'($urandom_range(prl_pkg::OP_LOOKUP, prl_pkg::OP_REM_HEAD));
      pid = (q_cnt > 0 && $urandom_range(3) != 0) ? q_pid[$urandom_range(q_cnt - 1)]
                                                   : 16'($urandom_range(31));
      if ($urandom_range(9) == 0) pid = 16'($urandom);
      send_item(op, pid, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)),
                16'($urandom), 0, none);
    end
    start <= 0;

    wait_c = 0;
    while (pending_res.size() != 0 && wait_c < 1000) begin
      @(posedge clk);
      wait_c++;
    end
    repeat (10) @(posedge clk);
    if (pending_res.size() != 0) errors++;
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/prl_pkg.sv
hdl/prl_ctrl.sv
hdl/prl_dp.sv
hdl/priority_ready_list_with_cursor.sv
hdl/prl_checker.sv
verif/tb.sv
